/* hdl/twpwm_pkg.sv */
// Shared types, constants and helper functions of the two-wire parity word master.
`timescale 1ns / 1ps
`default_nettype none

package twpwm_pkg;

	// Word layout: DATA_BITS of payload with a parity bit on top.
	localparam int DATA_BITS = 10;
	localparam int WORD_W    = DATA_BITS + 1;
	localparam int INDEX_W   = 4;
	localparam int HALF_W    = 16;

	localparam logic [HALF_W-1:0]    HALF_PERIOD_RESET = HALF_W'(10);
	localparam logic [WORD_W-1:0]    READ_INVALID      = WORD_W'(1024);
	localparam logic [DATA_BITS-1:0] READ_LIMIT        = DATA_BITS'(1020);
	localparam int                   QUEUE_DEPTH_DEF   = 4;

	// Codes of the kind field of an incoming word.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	// Operation after classification by the front end.
	typedef enum logic [1:0] {
		OP_TICK,
		OP_READ,
		OP_WRITE,
		OP_IGNORE
	} op_t;

	// One queued operation.
	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] word;
		logic              sda;
	} cmd_t;

	// Queue handshake between the front end and the sequencer.
	typedef struct packed {
		logic valid;
		logic pop;
	} queue_ctl_t;

	// Parity bit carried on top of a data word.
	function automatic logic low_parity(input logic [DATA_BITS-1:0] w);
		return ^w;
	endfunction

	// Checks a received word and clamps an invalid one above the marker value to it.
	function automatic logic [WORD_W-1:0] finish_read(input logic [WORD_W-1:0] b);
		logic [DATA_BITS-1:0] low;
		logic                 ok;
		low = b[DATA_BITS-1:0];
		ok  = (b[DATA_BITS] == low_parity(low));
		if (ok && (low < READ_LIMIT)) begin
			return {1'b0, low};
		end else if (b > READ_INVALID) begin
			return READ_INVALID;
		end else begin
			return b;
		end
	endfunction

endpackage

`default_nettype wire

/* hdl/twpwm_front.sv */
// Front end: accepts input words, classifies them and queues them for the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module twpwm_front #(
	parameter int QUEUE_DEPTH = twpwm_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     kind,
	input  wire logic [twpwm_pkg::DATA_BITS-1:0] address,
	input  wire logic                           sda_in,
	output twpwm_pkg::cmd_t                     q_cmd,
	input  wire twpwm_pkg::queue_ctl_t          q_ctl_in,
	output logic                                q_valid
);
	import twpwm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             cmd_c;
	cmd_t             queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	// Classify the incoming word and build the parity word for a write.
	always_comb begin
		cmd_c.sda  = sda_in;
		cmd_c.word = '0;
		unique case (kind)
			KIND_TICK:  cmd_c.op = OP_TICK;
			KIND_READ:  cmd_c.op = OP_READ;
			KIND_WRITE: begin
				cmd_c.op   = OP_WRITE;
				cmd_c.word = {low_parity(address), address};
			end
			default:    cmd_c.op = OP_IGNORE;
		endcase
	end

	assign in_stall = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign pop      = q_ctl_in.pop;
	assign q_valid  = (count_q != '0);
	assign q_cmd    = queue_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_c;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill count never exceeds the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// The sequencer never pops an empty queue, and it sees the word as waiting.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_valid && q_ctl_in.valid))
		else $error("pop from empty queue");

	// A push and no pop grows the fill count by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

endmodule

`default_nettype wire

/* hdl/twpwm_back.sv */
// Back end: line sequencer that executes queued operations and registers each result word.
`timescale 1ns / 1ps
`default_nettype none

module twpwm_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [twpwm_pkg::HALF_W-1:0]    half_period,
	input  wire twpwm_pkg::cmd_t                 q_cmd,
	input  wire logic                            q_valid,
	output twpwm_pkg::queue_ctl_t                q_ctl_out,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 scl,
	output logic                                 sda_out,
	output logic                                 sda_release,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic [twpwm_pkg::WORD_W-1:0]         read_value,
	output logic                                 rejected
);
	import twpwm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_A,
		PH_START_B,
		PH_START_C,
		PH_MODE_HI,
		PH_MODE_LO,
		PH_BIT_LO,
		PH_BIT_HI,
		PH_BIT_GAP,
		PH_STOP_A,
		PH_STOP_B,
		PH_STOP_C
	} phase_t;

	phase_t              phase_q,  phase_n,  enter_ph;
	logic                is_read_q, is_read_n;
	logic [INDEX_W-1:0]  bit_q,    bit_n;
	logic [HALF_W-1:0]   wait_q,   wait_n;
	logic [WORD_W-1:0]   shift_q,  shift_n;
	logic                clk_lvl_q, clk_lvl_n;
	logic                dat_lvl_q, dat_lvl_n;
	logic [WORD_W-1:0]   last_q,   last_n;
	logic                busy, busy_n, done_c, rej_c, enter_en, pop;
	logic [HALF_W-1:0]   hold;
	logic                last_bit;

	assign pop       = q_valid && (!out_valid || !out_stall);
	assign q_ctl_out = '{valid: q_valid, pop: pop};
	assign busy      = (phase_q != PH_IDLE);
	assign hold      = (half_period == '0) ? HALF_W'(1) : half_period;
	assign last_bit  = (bit_q >= INDEX_W'(DATA_BITS));

	// Next-state logic for one operation: tick, command or ignored word.
	always_comb begin
		phase_n   = phase_q;
		is_read_n = is_read_q;
		bit_n     = bit_q;
		wait_n    = wait_q;
		shift_n   = shift_q;
		clk_lvl_n = clk_lvl_q;
		dat_lvl_n = dat_lvl_q;
		last_n    = last_q;
		done_c    = 1'b0;
		rej_c     = 1'b0;
		enter_en  = 1'b0;
		enter_ph  = PH_IDLE;

		unique case (q_cmd.op)
			OP_TICK: begin
				if (busy) begin
					if (wait_q > HALF_W'(1)) begin
						wait_n = wait_q - 1'b1;
					end else begin
						enter_en = 1'b1;
						unique case (phase_q)
							PH_START_A: enter_ph = PH_START_B;
							PH_START_B: enter_ph = PH_START_C;
							PH_START_C: enter_ph = PH_MODE_HI;
							PH_MODE_HI: enter_ph = PH_MODE_LO;
							PH_MODE_LO: begin
								bit_n    = '0;
								enter_ph = PH_BIT_LO;
							end
							PH_BIT_LO: begin
								if (is_read_q) begin
									shift_n = {shift_q[WORD_W-2:0], q_cmd.sda};
								end
								enter_ph = PH_BIT_HI;
							end
							PH_BIT_HI: begin
								if (!is_read_q) begin
									enter_ph = PH_BIT_GAP;
								end else if (last_bit) begin
									enter_ph = PH_STOP_A;
								end else begin
									bit_n    = bit_q + 1'b1;
									enter_ph = PH_BIT_LO;
								end
							end
							PH_BIT_GAP: begin
								shift_n = {shift_q[WORD_W-2:0], 1'b0};
								if (last_bit) begin
									enter_ph = PH_STOP_A;
								end else begin
									bit_n    = bit_q + 1'b1;
									enter_ph = PH_BIT_LO;
								end
							end
							PH_STOP_A: enter_ph = PH_STOP_B;
							PH_STOP_B: enter_ph = PH_STOP_C;
							PH_STOP_C: begin
								if (is_read_q) begin
									last_n = finish_read(shift_q);
								end
								done_c   = 1'b1;
								enter_ph = PH_IDLE;
							end
							default:   enter_ph = PH_IDLE;
						endcase
					end
				end
			end
			OP_READ, OP_WRITE: begin
				if (busy) begin
					rej_c = 1'b1;
				end else begin
					is_read_n = (q_cmd.op == OP_READ);
					bit_n     = '0;
					shift_n   = (q_cmd.op == OP_READ) ? '0 : q_cmd.word;
					enter_en  = 1'b1;
					enter_ph  = PH_START_A;
				end
			end
			default: ;
		endcase

		// Entering a phase loads the hold count and sets the line levels.
		if (enter_en) begin
			phase_n = enter_ph;
			wait_n  = hold;
			unique case (enter_ph)
				PH_START_A: begin clk_lvl_n = 1'b1; dat_lvl_n = 1'b1; end
				PH_START_B: begin clk_lvl_n = 1'b1; dat_lvl_n = 1'b0; end
				PH_START_C: begin clk_lvl_n = 1'b0; dat_lvl_n = 1'b0; end
				PH_MODE_HI: begin clk_lvl_n = 1'b1; dat_lvl_n = is_read_n; end
				PH_MODE_LO: begin clk_lvl_n = 1'b0; dat_lvl_n = is_read_n; end
				PH_BIT_LO: begin
					clk_lvl_n = 1'b0;
					dat_lvl_n = is_read_n ? 1'b1 : shift_n[DATA_BITS];
				end
				PH_BIT_HI:  clk_lvl_n = 1'b1;
				PH_BIT_GAP: clk_lvl_n = 1'b0;
				PH_STOP_A:  begin clk_lvl_n = 1'b0; dat_lvl_n = 1'b0; end
				PH_STOP_B:  begin clk_lvl_n = 1'b1; dat_lvl_n = 1'b0; end
				PH_STOP_C:  begin clk_lvl_n = 1'b1; dat_lvl_n = 1'b1; end
				default: begin
					wait_n    = '0;
					clk_lvl_n = 1'b1;
					dat_lvl_n = 1'b1;
				end
			endcase
		end
	end

	assign busy_n = (phase_n != PH_IDLE);

	// Sequencer state and the registered result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			is_read_q <= 1'b0;
			bit_q     <= '0;
			wait_q    <= '0;
			shift_q   <= '0;
			clk_lvl_q <= 1'b1;
			dat_lvl_q <= 1'b1;
			last_q    <= READ_INVALID;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_n;
				is_read_q   <= is_read_n;
				bit_q       <= bit_n;
				wait_q      <= wait_n;
				shift_q     <= shift_n;
				clk_lvl_q   <= clk_lvl_n;
				dat_lvl_q   <= dat_lvl_n;
				last_q      <= last_n;
				out_valid   <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload, loaded with each executed operation.
	always_ff @(posedge clk) begin
		if (pop) begin
			scl         <= clk_lvl_n;
			sda_out     <= dat_lvl_n;
			sda_release <= busy_n && is_read_n &&
				((phase_n == PH_BIT_LO) || (phase_n == PH_BIT_HI));
			busy_res    <= busy_n;
			done_res    <= done_c;
			read_value  <= last_n;
			rejected    <= rej_c;
		end
	end

	// While a transaction runs the hold count is never zero.
	a_hold_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (wait_q != '0))
		else $error("busy with zero hold count");

	// A finished transaction leaves the sequencer idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> !busy_res)
		else $error("done reported while still busy");

	// A command is only rejected while a transaction is running.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected) |-> busy_res)
		else $error("reject reported while idle");

endmodule

`default_nettype wire

/* hdl/two_wire_parity_word_master.sv */
// Top level of the two-wire parity word master: configuration register, front end and sequencer.
//
// Usage: every input word carries kind, address and sda_in and is taken when in_valid is high
// and in_stall is low. A tick word advances the line sequencer by one prescaler tick, a read
// or write word starts a transaction when idle and is rejected while one runs, and kind three
// is dropped with no tick. Every input word yields exactly one result word on the output
// channel (scl, sda_out, sda_release, busy_res, done_res, read_value, rejected), taken when
// out_valid is high and out_stall is low. A new word is taken every cycle while out_stall
// allows: one word per cycle sustained. The sequencer evaluates a whole tick combinationally.
// half_period is written through cfg_we and cfg_data while the block is idle, a rule for the
// user that the block does not enforce; a value of zero holds each level for one tick. At
// reset the queue is empty, the line levels idle high, half_period is 10 and the stored read
// value is 1024. When the receiver stalls, the current result word holds, the sequencer
// waits and up to QUEUE_DEPTH input words collect in the queue before in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module two_wire_parity_word_master #(
	parameter int QUEUE_DEPTH = twpwm_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [twpwm_pkg::HALF_W-1:0]    cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      kind,
	input  wire logic [twpwm_pkg::DATA_BITS-1:0] address,
	input  wire logic                            sda_in,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 scl,
	output logic                                 sda_out,
	output logic                                 sda_release,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic [twpwm_pkg::WORD_W-1:0]         read_value,
	output logic                                 rejected
);
	import twpwm_pkg::*;

	logic [HALF_W-1:0] half_period_q;
	cmd_t              q_cmd;
	logic              q_valid;
	queue_ctl_t        q_ctl;

	// Hold time register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_period_q <= cfg_data;
		end
	end

	twpwm_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.address  (address),
		.sda_in   (sda_in),
		.q_cmd    (q_cmd),
		.q_ctl_in (q_ctl),
		.q_valid  (q_valid)
	);

	twpwm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_period (half_period_q),
		.q_cmd       (q_cmd),
		.q_valid     (q_valid),
		.q_ctl_out   (q_ctl),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl         (scl),
		.sda_out     (sda_out),
		.sda_release (sda_release),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.read_value  (read_value),
		.rejected    (rejected)
	);

endmodule

`default_nettype wire

/* tb/tb_two_wire_parity_word_master.sv */
// Self-checking testbench for the two-wire parity word master.
`timescale 1ns / 1ps

module tb_two_wire_parity_word_master;
	import twpwm_pkg::*;

	// Kind three is dropped by the block without counting as a tick.
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int TARGET_WORDS  = 1800;
	localparam int HOLD_CYCLES   = 300;
	localparam int LIMIT_NS      = 5_000_000;

	// Line sequencer phases, in the order a transaction walks through them.
	typedef enum logic [3:0] {
		ST_IDLE, ST_START_A, ST_START_B, ST_START_C, ST_MODE_HI, ST_MODE_LO,
		ST_BIT_LO, ST_BIT_HI, ST_BIT_GAP, ST_STOP_A, ST_STOP_B, ST_STOP_C
	} line_phase_t;

	// Receiver stall patterns.
	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} stall_pattern_t;

	// One result word as seen on the output channel.
	typedef struct packed {
		logic              scl;
		logic              sda_out;
		logic              sda_rel;
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] value;
		logic              rejected;
	} line_result_t;

	// One entry of the stimulus list: an input word or a half_period write.
	typedef struct packed {
		logic              is_cfg;
		logic [HALF_W-1:0] cfg_val;
		logic [1:0]        kind;
		logic [9:0]        addr;
		logic              sda;
	} stim_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [HALF_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        kind = KIND_TICK;
	logic [9:0]        address = '0;
	logic              sda_in = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              scl;
	logic              sda_out;
	logic              sda_release;
	logic              busy_res;
	logic              done_res;
	logic [WORD_W-1:0] read_value;
	logic              rejected;

	two_wire_parity_word_master dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.address    (address),
		.sda_in     (sda_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl        (scl),
		.sda_out    (sda_out),
		.sda_release(sda_release),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_value (read_value),
		.rejected   (rejected)
	);

	stim_t        stim_list[$];
	line_result_t line_expected[$];
	int           errors = 0;
	int           n_words = 0;
	int           n_checked = 0;
	int           n_done = 0;
	int           n_rejected = 0;
	int           n_cfg = 0;
	logic [HALF_W-1:0] gen_half = HALF_PERIOD_RESET;

	// Predictor state: a copy of the register and of the sequencer.
	logic [HALF_W-1:0] lk_half = HALF_PERIOD_RESET;
	line_phase_t       lk_phase = ST_IDLE;
	logic              lk_read = 1'b0;
	logic [3:0]        lk_bit = '0;
	logic [HALF_W-1:0] lk_wait = '0;
	logic [WORD_W-1:0] lk_shift = '0;
	logic              lk_scl = 1'b1;
	logic              lk_sda = 1'b1;
	logic [WORD_W-1:0] lk_last = READ_INVALID;

	// A received word keeps its low bits only when parity holds and it is in range.
	function automatic logic [WORD_W-1:0] judge_word(input logic [WORD_W-1:0] w);
		logic [DATA_BITS-1:0] low;
		low = w[DATA_BITS-1:0];
		if (w[DATA_BITS] == ^low && low < READ_LIMIT)
			return {1'b0, low};
		if (w > READ_INVALID)
			return READ_INVALID;
		return w;
	endfunction

	// Enter a phase: set the line levels and reload the hold count.
	function automatic void line_enter(input line_phase_t p);
		lk_phase = p;
		lk_wait = (lk_half == 0) ? HALF_W'(1) : lk_half;
		case (p)
		ST_START_A: begin lk_scl = 1'b1; lk_sda = 1'b1; end
		ST_START_B: begin lk_scl = 1'b1; lk_sda = 1'b0; end
		ST_START_C: begin lk_scl = 1'b0; lk_sda = 1'b0; end
		ST_MODE_HI: begin lk_scl = 1'b1; lk_sda = lk_read; end
		ST_MODE_LO: begin lk_scl = 1'b0; lk_sda = lk_read; end
		ST_BIT_LO: begin
			lk_scl = 1'b0;
			lk_sda = lk_read ? 1'b1 : lk_shift[DATA_BITS];
		end
		ST_BIT_HI: lk_scl = 1'b1;
		ST_BIT_GAP: lk_scl = 1'b0;
		ST_STOP_A: begin lk_scl = 1'b0; lk_sda = 1'b0; end
		ST_STOP_B: begin lk_scl = 1'b1; lk_sda = 1'b0; end
		ST_STOP_C: begin lk_scl = 1'b1; lk_sda = 1'b1; end
		default: begin
			lk_phase = ST_IDLE;
			lk_wait = '0;
			lk_scl = 1'b1;
			lk_sda = 1'b1;
		end
		endcase
	endfunction

	// The hold time has run out: move to the next phase. Returns 1 at the end of a stop.
	function automatic logic line_advance(input logic s);
		logic fin;
		fin = 1'b0;
		case (lk_phase)
		ST_START_A: line_enter(ST_START_B);
		ST_START_B: line_enter(ST_START_C);
		ST_START_C: line_enter(ST_MODE_HI);
		ST_MODE_HI: line_enter(ST_MODE_LO);
		ST_MODE_LO: begin
			lk_bit = '0;
			line_enter(ST_BIT_LO);
		end
		ST_BIT_LO: begin
			if (lk_read)
				lk_shift = {lk_shift[WORD_W-2:0], s};
			line_enter(ST_BIT_HI);
		end
		ST_BIT_HI: begin
			if (!lk_read) begin
				line_enter(ST_BIT_GAP);
			end else if (lk_bit >= DATA_BITS) begin
				line_enter(ST_STOP_A);
			end else begin
				lk_bit++;
				line_enter(ST_BIT_LO);
			end
		end
		ST_BIT_GAP: begin
			lk_shift = {lk_shift[WORD_W-2:0], 1'b0};
			if (lk_bit >= DATA_BITS) begin
				line_enter(ST_STOP_A);
			end else begin
				lk_bit++;
				line_enter(ST_BIT_LO);
			end
		end
		ST_STOP_A: line_enter(ST_STOP_B);
		ST_STOP_B: line_enter(ST_STOP_C);
		ST_STOP_C: begin
			if (lk_read)
				lk_last = judge_word(lk_shift);
			line_enter(ST_IDLE);
			fin = 1'b1;
		end
		default: line_enter(ST_IDLE);
		endcase
		return fin;
	endfunction

	// Work out the result word caused by one accepted input word.
	function automatic line_result_t line_step(input logic [1:0] k, input logic [9:0] a,
			input logic s);
		line_result_t r;
		logic busy;
		r = '0;
		busy = (lk_phase != ST_IDLE);
		case (k)
		KIND_TICK: begin
			if (busy) begin
				if (lk_wait != 0)
					lk_wait--;
				if (lk_wait == 0)
					r.done = line_advance(s);
			end
		end
		KIND_READ, KIND_WRITE: begin
			if (busy) begin
				r.rejected = 1'b1;
			end else begin
				lk_read = (k == KIND_READ);
				lk_bit = '0;
				lk_shift = lk_read ? '0 : {^a, a};
				line_enter(ST_START_A);
			end
		end
		default: ;
		endcase
		busy = (lk_phase != ST_IDLE);
		r.scl = lk_scl;
		r.sda_out = lk_sda;
		r.sda_rel = busy && lk_read && (lk_phase == ST_BIT_LO || lk_phase == ST_BIT_HI);
		r.busy = busy;
		r.value = lk_last;
		return r;
	endfunction

	// Stimulus list helpers.
	task automatic push_word(input logic [1:0] k, input logic [9:0] a, input logic s);
		stim_t e;
		e = '0;
		e.kind = k;
		e.addr = a;
		e.sda = s;
		stim_list.push_back(e);
		if (k != KIND_NONE)
			n_words++;
	endtask

	task automatic push_cfg(input logic [HALF_W-1:0] v);
		stim_t e;
		e = '0;
		e.is_cfg = 1'b1;
		e.cfg_val = v;
		stim_list.push_back(e);
		gen_half = v;
	endtask

	// Now and then a command that must be rejected, or a dropped word, inside a transaction.
	task automatic push_noise_maybe();
		int pick;
		pick = $urandom_range(0, 23);
		if (pick == 0)
			stim_list.push_back('{1'b0, 16'd0, KIND_READ, 10'($urandom), 1'($urandom)});
		else if (pick == 1)
			stim_list.push_back('{1'b0, 16'd0, KIND_WRITE, 10'($urandom), 1'($urandom)});
		else if (pick == 2)
			stim_list.push_back('{1'b0, 16'd0, KIND_NONE, 10'($urandom), 1'($urandom)});
	endtask

	// A read with the slave presenting the given word, one bit per clock rise.
	task automatic push_read(input logic [WORD_W-1:0] w);
		int h;
		int t;
		int slot;
		h = (gen_half == 0) ? 1 : int'(gen_half);
		push_word(KIND_READ, 10'($urandom), 1'($urandom));
		for (t = 1; t <= 30 * h; t++) begin
			push_noise_maybe();
			slot = t / h;
			if (t % h == 0 && slot >= 6 && slot <= 26 && slot % 2 == 0)
				push_word(KIND_TICK, 10'($urandom), w[DATA_BITS - (slot - 6) / 2]);
			else
				push_word(KIND_TICK, 10'($urandom), 1'($urandom));
		end
	endtask

	// A write of one address, followed by exactly the ticks it takes.
	task automatic push_write(input logic [9:0] a);
		int h;
		int t;
		h = (gen_half == 0) ? 1 : int'(gen_half);
		push_word(KIND_WRITE, a, 1'($urandom));
		for (t = 1; t <= 41 * h; t++) begin
			push_noise_maybe();
			push_word(KIND_TICK, 10'($urandom), 1'($urandom));
		end
	endtask

	// Ticks and dropped words while the bus is idle.
	task automatic push_idle(input int n);
		int i;
		for (i = 0; i < n; i++)
			push_word($urandom_range(0, 1) ? KIND_TICK : KIND_NONE, 10'($urandom),
				1'($urandom));
	endtask

	// Read word with a chosen flavor: good, good parity but out of range, bad parity, raw.
	function automatic logic [WORD_W-1:0] pick_read_word();
		logic [9:0] low;
		case ($urandom_range(0, 5))
		0, 1, 2: begin
			low = 10'($urandom_range(0, 1019));
			return {^low, low};
		end
		3: begin
			low = 10'($urandom_range(1020, 1023));
			return {^low, low};
		end
		4: begin
			low = 10'($urandom);
			return {~^low, low};
		end
		default: return WORD_W'($urandom);
		endcase
	endfunction

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Fixed limit on the whole run.
	initial begin
		#(LIMIT_NS);
		$display("tb_two_wire_parity_word_master: FAIL");
		$finish;
	end

	// Driver: offers words in bursts and writes half_period once everything has drained.
	int burst_left = 1;
	int gap_left = 0;
	int settle = 0;
	always @(posedge clk or negedge arst_n) begin
		logic valid_next;
		logic we_next;
		stim_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			valid_next = in_valid;
			we_next = 1'b0;
			if (in_valid && !in_stall) begin
				line_expected.push_back(line_step(kind, address, sda_in));
				valid_next = 1'b0;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					valid_next = 1'b0;
				end else if (stim_list.size() > 0 && stim_list[0].is_cfg) begin
					valid_next = 1'b0;
					if (in_valid || line_expected.size() != 0) begin
						settle = 0;
					end else if (settle < SETTLE_CYCLES) begin
						settle++;
					end else begin
						it = stim_list.pop_front();
						we_next = 1'b1;
						cfg_data <= it.cfg_val;
						lk_half = it.cfg_val;
						settle = 0;
						n_cfg++;
					end
				end else if (stim_list.size() > 0) begin
					it = stim_list.pop_front();
					kind <= it.kind;
					address <= it.addr;
					sda_in <= it.sda;
					valid_next = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
					end
				end else begin
					valid_next = 1'b0;
				end
			end
			in_valid <= valid_next;
			cfg_we <= we_next;
		end
	end

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Monitor: checks each result word against the oldest prediction and drives stalls.
	int             hold_left = 0;
	logic           hold_done = 1'b0;
	int             mode_left = 0;
	stall_pattern_t rx_pattern = RX_FREE;
	always @(posedge clk or negedge arst_n) begin
		logic stall_next;
		line_result_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (line_expected.size() == 0) begin
					errors++;
					$display("%0t: result word with no expectation, expected none, actual scl=%0b "
						, $time, scl, "sda=%0b value=%0d", sda_out, read_value);
				end else begin
					e = line_expected.pop_front();
					check_field("scl", WORD_W'(e.scl), WORD_W'(scl));
					check_field("sda_out", WORD_W'(e.sda_out), WORD_W'(sda_out));
					check_field("sda_release", WORD_W'(e.sda_rel), WORD_W'(sda_release));
					check_field("busy_res", WORD_W'(e.busy), WORD_W'(busy_res));
					check_field("done_res", WORD_W'(e.done), WORD_W'(done_res));
					check_field("read_value", e.value, read_value);
					check_field("rejected", WORD_W'(e.rejected), WORD_W'(rejected));
					n_checked++;
					if (e.done)
						n_done++;
					if (e.rejected)
						n_rejected++;
				end
			end
			// One long hold-off so the input queue fills, otherwise a changing pattern.
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!hold_done && n_checked >= 200) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				stall_next = 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_pattern = stall_pattern_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 150);
				end else begin
					mode_left--;
				end
				case (rx_pattern)
				RX_FREE: stall_next = 1'b0;
				RX_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
				RX_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
				default: stall_next = ~out_stall;
				endcase
			end
			out_stall <= stall_next;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [9:0] low;
		// Reset values: idle words, then a full read at the reset half_period.
		push_idle(3);
		low = 10'd1019;
		push_read({^low, low});
		// Zero half_period acts as one; field extremes and every read verdict.
		push_cfg(16'd0);
		push_write(10'd0);
		push_write(10'h3FF);
		push_read({1'b0, 10'd0} | {^10'd0, 10'd0});
		low = 10'd1020;
		push_read({^low, low});
		low = 10'd1023;
		push_read({^low, low});
		low = 10'd5;
		push_read({~^low, low});
		push_read(11'h7FF);
		push_idle(4);
		push_cfg(16'd1);
		push_write(10'h2AA);
		push_read(pick_read_word());

		// Random transactions under a changing half_period.
		while (n_words < TARGET_WORDS) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
				0: push_cfg(16'd0);
				1: push_cfg(16'd1);
				2: push_cfg(16'd2);
				default: push_cfg(16'($urandom_range(1, 5)));
				endcase
			end
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: push_read(pick_read_word());
			5, 6, 7: push_write(10'($urandom));
			default: push_idle($urandom_range(1, 6));
			endcase
		end

		// Longest half_period: a write that stays in its first level to the end.
		push_cfg(16'hFFFF);
		push_word(KIND_WRITE, 10'($urandom), 1'($urandom));
		begin
			int i;
			for (i = 0; i < 150; i++) begin
				push_noise_maybe();
				push_word(KIND_TICK, 10'($urandom), 1'($urandom));
			end
		end
		push_word(KIND_READ, 10'($urandom), 1'($urandom));
		push_word(KIND_NONE, 10'($urandom), 1'($urandom));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_list.size() != 0 || in_valid || line_expected.size() != 0)
			@(negedge clk);
		repeat (12) @(posedge clk);

		$display("Sent %0d words through %0d half_period settings; %0d results checked,",
			n_words, n_cfg, n_checked);
		$display("%0d transactions completed, %0d commands rejected while busy.",
			n_done, n_rejected);
		if (errors == 0 && line_expected.size() == 0)
			$display("tb_two_wire_parity_word_master: PASS");
		else
			$display("tb_two_wire_parity_word_master: FAIL");
		$finish;
	end

endmodule
